// ===== hw/rtl/ftq_pkg.sv =====
// Shared types and codes for the flow-controlled transmit queue.
// No dependencies.
package ftq_pkg;

  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_DONE = 2'd1,
    OP_FLOW = 2'd2,
    OP_CTX  = 2'd3
  } ftq_op_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_CONTINUE  = 3'd1,
    ST_STOP      = 3'd2,
    ST_DISCONN   = 3'd3,
    ST_TOO_LARGE = 3'd4
  } ftq_status_t;

  typedef enum logic [1:0] {
    CFG_HIGH_MARK = 2'd0,
    CFG_MAX_LEN   = 2'd1,
    CFG_SHUTDOWN  = 2'd2
  } ftq_cfg_idx_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ftq_state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ftq_cmd_t;

  typedef struct packed {
    logic out_busy;
  } ftq_stat_t;

  localparam int unsigned MarkWidth      = 5;
  localparam int unsigned LenWidth       = 16;
  localparam int unsigned TagWidth       = 16;
  localparam logic [4:0]  MarkReset      = 5'd1;
  localparam logic [15:0] MaxLenReset    = 16'd1500;

endpackage

// ===== hw/rtl/ftq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ftq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/ftq_ctrl.sv =====
// Controller: sequences accept and execute of one event at a time.
// Depends on ftq_pkg.
module ftq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ftq_pkg::ftq_stat_t stat,
  output ftq_pkg::ftq_cmd_t  cmd
);
  import ftq_pkg::*;

  ftq_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (!stat.out_busy) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/ftq_datapath.sv =====
// Datapath: config registers, link/flow flags, tag FIFO pointers, result register.
// Depends on ftq_pkg and ftq_ram.
module ftq_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [39:0]         in_data,
  input  logic [1:0]          in_user,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [31:0]         out_data,
  input  ftq_pkg::ftq_cmd_t   cmd,
  output ftq_pkg::ftq_stat_t  stat
);
  import ftq_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MW = (CW > MarkWidth) ? CW : MarkWidth;
  localparam logic [PW-1:0] LastSlot = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(QUEUE_DEPTH);

  // config
  logic [MarkWidth-1:0] high_mark;
  logic [LenWidth-1:0]  max_len;
  logic                 shutdown;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_mark <= MarkReset;
      max_len   <= MaxLenReset;
      shutdown  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HIGH_MARK: high_mark <= cfg_data[MarkWidth-1:0];
        CFG_MAX_LEN:   max_len   <= cfg_data;
        CFG_SHUTDOWN:  shutdown  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // latched event
  ftq_op_t             op_q;
  logic [TagWidth-1:0] tag_q;
  logic [LenWidth-1:0] len_q;
  logic                flag_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= ftq_op_t'(in_user);
      tag_q  <= in_data[15:0];
      len_q  <= in_data[31:16];
      flag_q <= in_data[32];
    end
  end

  // state
  logic          busy, flow, ctx;
  logic [PW-1:0] head, tail;
  logic [CW-1:0] count;
  logic          busy_next, flow_next, ctx_next;
  logic [PW-1:0] head_next, tail_next;
  logic [CW-1:0] count_next;

  logic [TagWidth-1:0] rdata;
  logic                we;

  ftq_ram #(
    .WIDTH(TagWidth),
    .DEPTH(QUEUE_DEPTH)
  ) u_tag_ram (
    .clk  (clk),
    .we   (we),
    .waddr(tail),
    .wdata(tag_q),
    .raddr(head),
    .rdata(rdata)
  );

  function automatic logic [PW-1:0] inc_slot(input logic [PW-1:0] p);
    return (p == LastSlot) ? '0 : PW'(p + PW'(1));
  endfunction

  function automatic logic mark_hit(input logic [CW-1:0] c, input logic [MarkWidth-1:0] m);
    return MW'(c) >= MW'(m);
  endfunction

  ftq_status_t         st;
  logic                dv, ru, ovf, do_resume;
  logic [TagWidth-1:0] dt;
  logic [CW-1:0]       count_inc;

  assign count_inc = CW'(count + CW'(1));

  always_comb begin
    busy_next  = busy;
    flow_next  = flow;
    ctx_next   = ctx;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    we         = 1'b0;
    st         = ST_NONE;
    dv         = 1'b0;
    dt         = '0;
    ru         = 1'b0;
    ovf        = 1'b0;
    do_resume  = 1'b0;
    unique case (op_q)
      OP_SEND: begin
        if (shutdown) begin
          st = ST_DISCONN;
        end else if (len_q > max_len) begin
          st = ST_TOO_LARGE;
        end else if (busy) begin
          if (count == FullCount) begin
            ovf = 1'b1;
            st  = ST_STOP;
          end else begin
            we         = cmd.exec;
            tail_next  = inc_slot(tail);
            count_next = count_inc;
            st         = mark_hit(count_inc, high_mark) ? ST_STOP : ST_CONTINUE;
          end
        end else begin
          dv        = 1'b1;
          busy_next = 1'b1;
          if (count != '0) begin
            dt        = rdata;
            head_next = inc_slot(head);
            tail_next = inc_slot(tail);
            we        = cmd.exec;
          end else begin
            dt = tag_q;
          end
          st = mark_hit(count, high_mark) ? ST_STOP : ST_CONTINUE;
        end
      end
      OP_DONE: begin
        busy_next = 1'b0;
        do_resume = ctx && !flow;
      end
      OP_FLOW: begin
        if (flow != flag_q) begin
          flow_next = flag_q;
          if (!flag_q) begin
            do_resume = ctx && !busy;
          end else begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
          end
        end
      end
      OP_CTX: begin
        if (ctx != flag_q) begin
          ctx_next = flag_q;
          if (flag_q) begin
            do_resume = !flow && !busy;
          end else begin
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
          end
        end
      end
      default: ;
    endcase
    if (do_resume) begin
      if (count != '0) begin
        dt         = rdata;
        dv         = 1'b1;
        head_next  = inc_slot(head);
        count_next = CW'(count - CW'(1));
        busy_next  = 1'b1;
      end
      ru = (count_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      flow  <= 1'b0;
      ctx   <= 1'b1;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.exec) begin
      busy  <= busy_next;
      flow  <= flow_next;
      ctx   <= ctx_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data <= {5'd0, ovf, MarkWidth'(count_next), ru, dt, dv, st};
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

endmodule

// ===== hw/rtl/flow_controlled_tx_queue_top.sv =====
// Top level of the flow-controlled transmit queue.
// Depends on ftq_pkg, ftq_ctrl, ftq_datapath, ftq_ram.
//
// One event beat in, one result beat out. Each event has an accept cycle, in
// which the tag RAM reads the FIFO head, and an execute cycle, which updates
// flags, pointers and RAM and loads the result register. The next event is
// taken the cycle after execute, so no new event is accepted before the last
// one has executed; execute waits while an earlier result is still held
// untaken in the result register. Config writes are always ready and take
// effect at once; they are meant to be written while no event is in flight.
// The tag FIFO holds QUEUE_DEPTH entries and needs no clearing after reset.
module flow_controlled_tx_queue_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // packet_tag, payload_length, flag_value, zero pad
  input  logic [1:0]  s_tuser,   // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // status, dispatch_valid, dispatch_tag, resume_upper,
                                 // queue_count, overflow, zero pad
);
  import ftq_pkg::*;

  ftq_cmd_t  cmd;
  ftq_stat_t stat;

  assign cfg_ready = 1'b1;

  ftq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  ftq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_data  (s_tdata),
    .in_user  (s_tuser),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_data (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ===== bench/flow_controlled_tx_queue_top_test.sv =====
// Self-checking bench for flow_controlled_tx_queue_top: a directed table, then
// randomized event phases under several register settings, checked beat by beat.
// Depends on ftq_pkg and the flow_controlled_tx_queue_top RTL.
`timescale 1ns / 100ps

module flow_controlled_tx_queue_top_test;
  import ftq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct packed {
    logic        overflow;
    logic [4:0]  queue_count;
    logic        resume_upper;
    logic [15:0] dispatch_tag;
    logic        dispatch_valid;
    ftq_status_t status;
  } tx_result_t;

  typedef struct {
    ftq_op_t     op;
    logic [15:0] tag;
    logic [15:0] len;
    logic        flag;
    logic        typed;
    tx_result_t  want;
  } event_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_HIGH_MARK;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // packet_tag, payload_length, flag_value, zero pad
  logic [1:0]  s_tuser = OP_SEND;   // operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;   // status, dispatch_valid, dispatch_tag, resume_upper,
                          // queue_count, overflow, zero pad

  // predictor state
  logic        gate_busy;
  logic        flow_on;
  logic        ctx_on;
  logic [15:0] tag_store [QUEUE_DEPTH];
  logic [3:0]  rd_ptr;
  logic [3:0]  wr_ptr;
  logic [4:0]  waiting;
  logic [4:0]  stop_mark;
  logic [15:0] len_limit;
  logic        refusing;

  tx_result_t  due_results [$];
  int unsigned mismatches = 0;
  int unsigned quiet = 0;
  int unsigned stall_left = 0;
  logic        calm = 1'b0;

  flow_controlled_tx_queue_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_tag(logic [15:0] tag);
    tag_store[wr_ptr] = tag;
    wr_ptr = wr_ptr + 4'd1;
    waiting = waiting + 5'd1;
  endfunction

  function automatic logic [15:0] pop_tag();
    logic [15:0] tag;
    tag = tag_store[rd_ptr];
    rd_ptr = rd_ptr + 4'd1;
    waiting = waiting - 5'd1;
    return tag;
  endfunction

  function automatic void flush_tags();
    rd_ptr = '0;
    wr_ptr = '0;
    waiting = '0;
  endfunction

  // hand the head to the link if idle; upper layer resumes once drained
  function automatic void try_resume(inout tx_result_t r);
    if (!gate_busy) begin
      if (waiting != 0) begin
        r.dispatch_tag = pop_tag();
        r.dispatch_valid = 1'b1;
        gate_busy = 1'b1;
      end
      if (waiting == 0) r.resume_upper = 1'b1;
    end
  endfunction

  function automatic tx_result_t advance_gate(ftq_op_t op, logic [15:0] tag,
                                              logic [15:0] len, logic flag);
    tx_result_t r;
    r = '0;
    case (op)
      OP_SEND: begin
        if (refusing) begin
          r.status = ST_DISCONN;
        end else if (len > len_limit) begin
          r.status = ST_TOO_LARGE;
        end else if (gate_busy) begin
          if (waiting == QUEUE_DEPTH) begin
            r.overflow = 1'b1;
            r.status = ST_STOP;
          end else begin
            push_tag(tag);
            r.status = (waiting >= stop_mark) ? ST_STOP : ST_CONTINUE;
          end
        end else begin
          if (waiting != 0) begin
            r.dispatch_tag = pop_tag();
            push_tag(tag);
          end else begin
            r.dispatch_tag = tag;
          end
          r.dispatch_valid = 1'b1;
          gate_busy = 1'b1;
          r.status = (waiting >= stop_mark) ? ST_STOP : ST_CONTINUE;
        end
      end
      OP_DONE: begin
        gate_busy = 1'b0;
        if (ctx_on && !flow_on) try_resume(r);
      end
      OP_FLOW: begin
        if (flow_on != flag) begin
          flow_on = flag;
          if (flag) flush_tags();
          else if (ctx_on) try_resume(r);
        end
      end
      default: begin
        if (ctx_on != flag) begin
          ctx_on = flag;
          if (!flag) flush_tags();
          else if (!flow_on) try_resume(r);
        end
      end
    endcase
    r.queue_count = waiting;
    return r;
  endfunction

  function automatic tx_result_t res(ftq_status_t st, logic dv, logic [15:0] dt,
                                     logic ru, logic [4:0] qc);
    tx_result_t r;
    r = '0;
    r.status = st;
    r.dispatch_valid = dv;
    r.dispatch_tag = dt;
    r.resume_upper = ru;
    r.queue_count = qc;
    return r;
  endfunction

  function automatic event_row_t row(ftq_op_t op, logic [15:0] tag, logic [15:0] len,
                                     logic flag, logic typed, tx_result_t want);
    event_row_t e;
    e.op = op;
    e.tag = tag;
    e.len = len;
    e.flag = flag;
    e.typed = typed;
    e.want = want;
    return e;
  endfunction

  task automatic send_event(event_row_t e);
    int unsigned gap;
    tx_result_t pred;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= e.op;
    s_tdata <= {7'd0, e.flag, e.len, e.tag};
    do @(posedge clk); while (!s_tready);
    pred = advance_gate(e.op, e.tag, e.len, e.flag);
    due_results.push_back(e.typed ? e.want : pred);
  endtask

  task automatic write_regs(logic [4:0] mark, logic [15:0] lim, logic shut);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_HIGH_MARK;
    cfg_data <= {11'd0, mark};
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_MAX_LEN;
    cfg_data <= lim;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_SHUTDOWN;
    cfg_data <= {15'd0, shut};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    stop_mark = mark;
    len_limit = lim;
    refusing = shut;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // result side: random stalls, then compare against the oldest expectation
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tx_result_t got;
    tx_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = tx_result_t'(m_tdata[26:0]);
      if (due_results.size() == 0) begin
        $error("result beat with nothing pending: %h", m_tdata);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("status", want.status, got.status);
        check_field("dispatch_valid", want.dispatch_valid, got.dispatch_valid);
        check_field("dispatch_tag", want.dispatch_tag, got.dispatch_tag);
        check_field("resume_upper", want.resume_upper, got.resume_upper);
        check_field("queue_count", want.queue_count, got.queue_count);
        check_field("overflow", want.overflow, got.overflow);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("flow_controlled_tx_queue_top regression: fail");
        $finish;
      end
    end
  end

  initial begin
    event_row_t  rows [$];
    event_row_t  e;
    int unsigned p;
    int unsigned n;
    int unsigned items;
    int unsigned pct;
    int unsigned r;
    logic [4:0]  mark;
    logic [15:0] lim;
    logic        shut;

    gate_busy = 1'b0;
    flow_on = 1'b0;
    ctx_on = 1'b1;
    rd_ptr = '0;
    wr_ptr = '0;
    waiting = '0;
    stop_mark = MarkReset;
    len_limit = MaxLenReset;
    refusing = 1'b0;
    foreach (tag_store[i]) tag_store[i] = '0;

    // reset settings: mark 1, max length 1500, not shutting down
    rows.push_back(row(OP_SEND, 16'hFFFF, 16'd0, 1'b0, 1'b1,
                       res(ST_CONTINUE, 1'b1, 16'hFFFF, 1'b0, 5'd0)));
    rows.push_back(row(OP_SEND, 16'h0000, 16'd1500, 1'b1, 1'b1,
                       res(ST_STOP, 1'b0, 16'h0000, 1'b0, 5'd1)));
    rows.push_back(row(OP_SEND, 16'h1234, 16'd1501, 1'b0, 1'b1,
                       res(ST_TOO_LARGE, 1'b0, 16'h0000, 1'b0, 5'd1)));
    rows.push_back(row(OP_FLOW, 16'h0000, 16'd0, 1'b0, 1'b1,
                       res(ST_NONE, 1'b0, 16'h0000, 1'b0, 5'd1)));
    rows.push_back(row(OP_CTX, 16'h0000, 16'd0, 1'b1, 1'b1,
                       res(ST_NONE, 1'b0, 16'h0000, 1'b0, 5'd1)));
    rows.push_back(row(OP_DONE, 16'h0000, 16'd0, 1'b0, 1'b1,
                       res(ST_NONE, 1'b1, 16'h0000, 1'b1, 5'd0)));
    rows.push_back(row(OP_SEND, 16'hAAAA, 16'hFFFF, 1'b0, 1'b1,
                       res(ST_TOO_LARGE, 1'b0, 16'h0000, 1'b0, 5'd0)));
    rows.push_back(row(OP_FLOW, 16'h0000, 16'd0, 1'b1, 1'b1,
                       res(ST_NONE, 1'b0, 16'h0000, 1'b0, 5'd0)));
    rows.push_back(row(OP_SEND, 16'h5555, 16'd0, 1'b0, 1'b0, '0));
    rows.push_back(row(OP_DONE, 16'h0000, 16'd0, 1'b0, 1'b0, '0));
    rows.push_back(row(OP_SEND, 16'h1111, 16'd10, 1'b0, 1'b0, '0));
    rows.push_back(row(OP_FLOW, 16'h0000, 16'd0, 1'b0, 1'b0, '0));
    rows.push_back(row(OP_DONE, 16'h0000, 16'd0, 1'b0, 1'b0, '0));
    rows.push_back(row(OP_CTX, 16'h0000, 16'd0, 1'b0, 1'b0, '0));
    rows.push_back(row(OP_DONE, 16'h0000, 16'd0, 1'b0, 1'b0, '0));
    rows.push_back(row(OP_CTX, 16'h0000, 16'd0, 1'b1, 1'b0, '0));
    rows.push_back(row(OP_SEND, 16'h8000, 16'd1, 1'b0, 1'b0, '0));
    rows.push_back(row(OP_SEND, 16'h7FFF, 16'd1499, 1'b0, 1'b0, '0));
    rows.push_back(row(OP_SEND, 16'h0001, 16'd2, 1'b0, 1'b0, '0));
    rows.push_back(row(OP_CTX, 16'h0000, 16'd0, 1'b0, 1'b0, '0));
    rows.push_back(row(OP_DONE, 16'h0000, 16'd0, 1'b0, 1'b0, '0));
    rows.push_back(row(OP_SEND, 16'h00FF, 16'd1500, 1'b0, 1'b0, '0));
    rows.push_back(row(OP_CTX, 16'h0000, 16'd0, 1'b1, 1'b0, '0));
    rows.push_back(row(OP_DONE, 16'h0000, 16'd0, 1'b0, 1'b0, '0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_event(rows[i]);

    for (p = 0; p < 12; p++) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while (due_results.size() != 0) @(posedge clk);

      case (p)
        0: begin
          mark = 5'd0; lim = 16'd0; shut = 1'b0; pct = 60; calm = 1'b0; items = 100;
        end
        1: begin
          mark = 5'd16; lim = 16'hFFFF; shut = 1'b0; pct = 88; calm = 1'b0; items = 150;
        end
        2: begin
          mark = 5'd1; lim = 16'd1500; shut = 1'b1; pct = 55; calm = 1'b1; items = 40;
        end
        3: begin
          mark = 5'd5; lim = 16'd9000; shut = 1'b0; pct = 88; calm = 1'b0; items = 150;
        end
        default: begin
          mark = 5'($urandom_range(0, 16));
          r = $urandom_range(0, 3);
          lim = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 9000));
          shut = ($urandom_range(0, 9) == 0);
          r = $urandom_range(0, 2);
          pct = (r == 0) ? 50 : (r == 1) ? 70 : 88;
          calm = ($urandom_range(0, 3) == 0);
          items = 120;
        end
      endcase
      write_regs(mark, lim, shut);

      for (n = 0; n < items; n++) begin
        r = $urandom_range(0, 99);
        if (r < pct) e.op = OP_SEND;
        else if (r < pct + (100 - pct) / 2) e.op = OP_DONE;
        else if (r % 2) e.op = OP_FLOW;
        else e.op = OP_CTX;
        e.tag = 16'($urandom);
        e.flag = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 9);
        if (r < 7) e.len = 16'($urandom_range(0, len_limit));
        else if (r < 8 && len_limit != 16'hFFFF)
          e.len = len_limit + 16'($urandom_range(1, 16'hFFFF - len_limit));
        else e.len = 16'($urandom);
        e.typed = 1'b0;
        e.want = '0;
        send_event(e);
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("flow_controlled_tx_queue_top regression: pass");
    end else begin
      $display("flow_controlled_tx_queue_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== flow_controlled_tx_queue_top.f =====
hw/rtl/ftq_pkg.sv
hw/rtl/ftq_ram.sv
hw/rtl/ftq_ctrl.sv
hw/rtl/ftq_datapath.sv
hw/rtl/flow_controlled_tx_queue_top.sv
bench/flow_controlled_tx_queue_top_test.sv
